/* sv/ucr_pkg.sv */
// ----------------------------------------------------------------------------
// ucr_pkg
// Shared types and constants for the UTF-8 code point reverser: status codes,
// controller states and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ucr_pkg;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,    // taking bytes, waiting for terminator
		S_SINGLE,  // one result: empty string or error
		S_LOOK,    // read last byte of remaining string
		S_LOOKW,   // its offset gives the code point start
		S_FETCH,   // read next byte of current code point
		S_LOAD     // move byte into output register
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_byte;
		logic take_term;
		logic rd_look;
		logic rd_fetch;
		logic seg_set;
		logic load_byte;
		logic load_single;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic single;       // terminator now would give a single result
		logic last_in_seg;  // pointer is at the last byte of the code point
		logic end_zero;     // no code points left before this one
		logic out_free;     // output register can take a result this cycle
	} sts_t;

endpackage

`default_nettype wire

/* sv/ucr_dp.sv */
// ----------------------------------------------------------------------------
// ucr_dp
// Datapath: byte store with per-byte code point offset, UTF-8 checking,
// emission pointers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ucr_dp #(
	parameter int MAX_BYTES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ucr_pkg::cmd_t cmd,
	output ucr_pkg::sts_t      sts,
	input  wire logic [7:0]    in_byte,
	input  wire logic          out_stall,
	output logic               out_valid,
	output logic [7:0]         out_byte,
	output logic               byte_present,
	output logic               final_item,
	output logic [1:0]         status
);

	localparam int AW = $clog2(MAX_BYTES);
	localparam int CW = $clog2(MAX_BYTES + 1);

	// store entry: byte and its offset within the code point (0 = lead)
	logic [9:0]    mem [MAX_BYTES];
	logic [9:0]    rdata_q;

	logic [CW-1:0] fill_q;
	logic [1:0]    pend_q;
	logic [1:0]    err_q;
	logic [1:0]    off_q;
	logic [1:0]    sstat_q;
	logic [CW-1:0] end_q;
	logic [CW-1:0] seg_end_q;
	logic [CW-1:0] ptr_q;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          present_q;
	logic          final_q;
	logic [1:0]    status_q;

	logic          lead_ok;
	logic [1:0]    lead_pend;
	logic          cont_ok;
	logic          full;
	logic          wr_en;
	logic [1:0]    wr_off;
	logic [1:0]    term_st;
	logic [CW-1:0] end_m1;
	logic [CW-1:0] seg_start;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// lead byte classification by prefix
	always_comb begin
		lead_ok   = 1'b1;
		lead_pend = 2'd0;
		priority if (!in_byte[7]) begin
			lead_pend = 2'd0;
		end else if (in_byte[7:5] == 3'b110) begin
			lead_pend = 2'd1;
		end else if (in_byte[7:4] == 4'b1110) begin
			lead_pend = 2'd2;
		end else if (in_byte[7:3] == 5'b11110) begin
			lead_pend = 2'd3;
		end else begin
			lead_ok = 1'b0;
		end
	end

	assign cont_ok = (in_byte[7:6] == 2'b10);
	assign full    = (fill_q == CW'(MAX_BYTES));
	assign wr_en   = cmd.take_byte && (err_q == ucr_pkg::ST_OK) && !full &&
	                 ((pend_q != 2'd0) ? cont_ok : lead_ok);
	assign wr_off  = (pend_q != 2'd0) ? (off_q + 2'd1) : 2'd0;

	always_comb begin
		if (err_q != ucr_pkg::ST_OK) begin
			term_st = err_q;
		end else if (pend_q != 2'd0) begin
			term_st = ucr_pkg::ST_MALFORMED;
		end else begin
			term_st = ucr_pkg::ST_OK;
		end
	end

	assign end_m1    = end_q - CW'(1);
	assign seg_start = end_m1 - CW'(rdata_q[1:0]);
	assign rd_en     = cmd.rd_look || cmd.rd_fetch;
	assign rd_addr   = cmd.rd_look ? end_m1[AW-1:0] : ptr_q[AW-1:0];

	// byte store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= {in_byte, wr_off};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// string state and emission pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pend_q    <= 2'd0;
			err_q     <= ucr_pkg::ST_OK;
			off_q     <= 2'd0;
			sstat_q   <= ucr_pkg::ST_OK;
			end_q     <= '0;
			seg_end_q <= '0;
			ptr_q     <= '0;
		end else begin
			if (cmd.take_byte && err_q == ucr_pkg::ST_OK) begin
				if (full) begin
					err_q <= ucr_pkg::ST_OVERFLOW;
				end else if (pend_q != 2'd0) begin
					if (cont_ok) begin
						pend_q <= pend_q - 2'd1;
						off_q  <= wr_off;
						fill_q <= fill_q + CW'(1);
					end else begin
						err_q <= ucr_pkg::ST_MALFORMED;
					end
				end else if (lead_ok) begin
					pend_q <= lead_pend;
					off_q  <= 2'd0;
					fill_q <= fill_q + CW'(1);
				end else begin
					err_q <= ucr_pkg::ST_MALFORMED;
				end
			end
			if (cmd.take_term) begin
				sstat_q <= term_st;
				end_q   <= fill_q;
				fill_q  <= '0;
				pend_q  <= 2'd0;
				err_q   <= ucr_pkg::ST_OK;
				off_q   <= 2'd0;
			end
			if (cmd.seg_set) begin
				ptr_q     <= seg_start;
				seg_end_q <= end_q;
				end_q     <= seg_start;
			end
			if (cmd.load_byte) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end
	end

	assign sts.single      = (term_st != ucr_pkg::ST_OK) || (fill_q == '0);
	assign sts.last_in_seg = ((ptr_q + CW'(1)) == seg_end_q);
	assign sts.end_zero    = (end_q == '0);
	assign sts.out_free    = !out_valid_q || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_byte || cmd.load_single) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			out_byte_q <= rdata_q[9:2];
			present_q  <= 1'b1;
			final_q    <= sts.last_in_seg && sts.end_zero;
			status_q   <= ucr_pkg::ST_OK;
		end else if (cmd.load_single) begin
			out_byte_q <= 8'd0;
			present_q  <= 1'b0;
			final_q    <= 1'b1;
			status_q   <= sstat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_present = present_q;
	assign final_item   = final_q;
	assign status       = status_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_byte || cmd.load_single) |-> sts.out_free)
		else $error("output register overwritten while held");

	a_seg_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_set |-> (CW'(rdata_q[1:0]) < end_q))
		else $error("code point start falls before string start");

	a_term_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_term |=> (fill_q == '0) && (err_q == ucr_pkg::ST_OK))
		else $error("string state not cleared by terminator");

endmodule

`default_nettype wire

/* sv/ucr_ctrl.sv */
// ----------------------------------------------------------------------------
// ucr_ctrl
// Controller: takes input transactions and steps the emission sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module ucr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          terminator,
	input  wire ucr_pkg::sts_t sts,
	output ucr_pkg::cmd_t      cmd
);

	ucr_pkg::state_t state_q;
	ucr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ucr_pkg::S_IDLE: begin
				in_stall      = 1'b0;
				cmd.take_byte = in_valid && !terminator;
				cmd.take_term = in_valid && terminator;
				if (cmd.take_term) begin
					state_d = sts.single ? ucr_pkg::S_SINGLE : ucr_pkg::S_LOOK;
				end
			end
			ucr_pkg::S_SINGLE: begin
				if (sts.out_free) begin
					cmd.load_single = 1'b1;
					state_d         = ucr_pkg::S_IDLE;
				end
			end
			ucr_pkg::S_LOOK: begin
				cmd.rd_look = 1'b1;
				state_d     = ucr_pkg::S_LOOKW;
			end
			ucr_pkg::S_LOOKW: begin
				cmd.seg_set = 1'b1;
				state_d     = ucr_pkg::S_FETCH;
			end
			ucr_pkg::S_FETCH: begin
				cmd.rd_fetch = 1'b1;
				state_d      = ucr_pkg::S_LOAD;
			end
			ucr_pkg::S_LOAD: begin
				if (sts.out_free) begin
					cmd.load_byte = 1'b1;
					if (!sts.last_in_seg) begin
						state_d = ucr_pkg::S_FETCH;
					end else if (sts.end_zero) begin
						state_d = ucr_pkg::S_IDLE;
					end else begin
						state_d = ucr_pkg::S_LOOK;
					end
				end
			end
			default: begin
				state_d = ucr_pkg::S_IDLE;
			end
		endcase
	end

	a_term_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_term |=> (state_q != ucr_pkg::S_IDLE))
		else $error("terminator did not start emission");

endmodule

`default_nettype wire

/* sv/utf8_codepoint_reverse.sv */
// ----------------------------------------------------------------------------
// utf8_codepoint_reverse
// Buffers a UTF-8 string and sends it back with the code point order
// reversed, bytes inside each code point kept in order.
// ----------------------------------------------------------------------------
// Data bytes are taken one per cycle while idle into a MAX_BYTES-entry store,
// each tagged with its offset inside its code point (0 on the lead byte).
// Lead bytes are judged by prefix alone; a bad lead, a bad continuation or a
// sequence still open at the terminator gives one malformed result, and a
// byte beyond MAX_BYTES gives one overflow result. After the first error the
// rest of the string is dropped. A terminator transaction starts emission and
// stalls the input until the last result has been loaded into the output
// register. Emission walks the store backwards one code point at a time: one
// read of the code point's last byte finds its start from the stored offset,
// then each byte takes a store read and an output load, with any output stall
// holding the load. An empty string or an error gives one result. Results carry
// final_item on the last transaction of each string. The output register lets
// the next string's bytes come in while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_reverse #(
	parameter int MAX_BYTES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       terminator,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_present,
	output logic            final_item,
	output logic [1:0]      status
);

	ucr_pkg::cmd_t cmd;
	ucr_pkg::sts_t sts;

	// sequencing: input handshake and emission steps
	ucr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.terminator (terminator),
		.sts        (sts),
		.cmd        (cmd)
	);

	// store, checker, pointers and output register
	ucr_dp #(
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_byte      (in_byte),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.final_item   (final_item),
		.status       (status)
	);

endmodule

`default_nettype wire
